[sv/avtr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package avtr_pkg;

    localparam int PRICE_BITS    = 24;
    localparam int FRACTION_BITS = 8;
    localparam int AVG_BITS      = PRICE_BITS + FRACTION_BITS;
    localparam int AVG_OUT_BITS  = 32;
    localparam int RATIO_BITS    = 24;
    localparam int BARS_BITS     = 4;
    localparam int KEEP_BITS     = 4;

    // avg * (n - 1) + tr << F, with n - 1 at most thirteen
    localparam int PROD_BITS   = AVG_BITS + KEEP_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int RATIO_STEPS = AVG_BITS + RATIO_BITS - FRACTION_BITS;
    localparam int MAX_STEPS   = (RATIO_STEPS > SUM_BITS) ? RATIO_STEPS : SUM_BITS;
    localparam int STEP_BITS   = $clog2(MAX_STEPS);
    localparam int QUO_BITS    = (AVG_BITS > RATIO_BITS) ? AVG_BITS : RATIO_BITS + 1;
    localparam int REM_BITS    = PRICE_BITS + 1;

    localparam logic [BARS_BITS-1:0] WARMUP_BARS = 4'd15;
    localparam logic [KEEP_BITS-1:0] SMOOTH_KEEP = 4'd13;
    localparam logic [KEEP_BITS-1:0] SMOOTH_DIV  = 4'd14;

    localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

    typedef logic [PRICE_BITS-1:0] price_t;
    typedef logic [AVG_BITS-1:0]   avg_t;

endpackage

`default_nettype wire

[sv/average_true_range_ratio.sv]
`timescale 1ns / 1ps
`default_nettype none

// Wilder average true range (period fourteen) with the average over the close as Q0.24.
// One request is taken at a time: in_stall stays high from acceptance until the result
// is moved into the output register. The setup states S_DIFF, S_MAX and S_SUM come first,
// then one restoring divider runs, producing one quotient bit per cycle: 37 steps for the
// average and 48 for the ratio. A zero close skips the ratio steps, and the first bar
// after reset goes straight from idle to the done state. The output register lets the
// next request in while a result still waits on out_stall.
module average_true_range_ratio
    import avtr_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [PRICE_BITS-1:0]   bar_high,
    input  wire logic [PRICE_BITS-1:0]   bar_low,
    input  wire logic [PRICE_BITS-1:0]   bar_close,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [AVG_OUT_BITS-1:0]      range_average,
    output logic [RATIO_BITS-1:0]        range_ratio
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIFF      = 3'd1;
    localparam logic [2:0] S_MAX       = 3'd2;
    localparam logic [2:0] S_SUM       = 3'd3;
    localparam logic [2:0] S_DIV_AVG   = 3'd4;
    localparam logic [2:0] S_DIV_RATIO = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic                 out_valid_reg;
    price_t               prev_close_reg;
    avg_t                 smoothed_reg;
    logic [BARS_BITS-1:0] bars_reg;

    price_t               high_reg, low_reg, close_reg;
    price_t               d_hl_reg, d_h_reg, d_l_reg, tr_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [SUM_BITS-1:0]  dvd_reg;
    price_t               dvs_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic                 sat_reg;
    logic [AVG_OUT_BITS-1:0] avg_out_reg;
    logic [RATIO_BITS-1:0]   ratio_out_reg;

    logic                 in_take, out_free, warmup, step_last;
    logic [KEEP_BITS-1:0] mult_k, div_n;
    price_t               tr_max;
    logic [REM_BITS-1:0]  rem_shift, rem_next;
    logic                 q_bit;
    logic [QUO_BITS-1:0]  quo_next;
    avg_t                 avg_new;

    assign in_stall      = (state_reg != S_IDLE);
    assign in_take       = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign out_free      = !out_valid_reg || !out_stall;
    assign range_average = avg_out_reg;
    assign range_ratio   = ratio_out_reg;

    assign warmup    = (bars_reg < WARMUP_BARS);
    assign mult_k    = warmup ? KEEP_BITS'(bars_reg - 1'b1) : SMOOTH_KEEP;
    assign div_n     = warmup ? KEEP_BITS'(bars_reg) : SMOOTH_DIV;
    assign step_last = (step_reg == '0);

    always_comb
    begin
        tr_max = d_hl_reg;
        if (d_h_reg > tr_max)
        begin
            tr_max = d_h_reg;
        end
        if (d_l_reg > tr_max)
        begin
            tr_max = d_l_reg;
        end
    end

    // shared restoring divider step
    assign rem_shift = {rem_reg[REM_BITS-2:0], dvd_reg[SUM_BITS-1]};
    assign q_bit     = (rem_shift >= REM_BITS'(dvs_reg));
    assign rem_next  = q_bit ? (rem_shift - REM_BITS'(dvs_reg)) : rem_shift;
    assign quo_next  = {quo_reg[QUO_BITS-2:0], q_bit};
    assign avg_new   = AVG_BITS'(quo_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (bars_reg == '0) ? S_DONE : S_DIFF;
                end
            end
            S_DIFF:  state_next = S_MAX;
            S_MAX:   state_next = S_SUM;
            S_SUM:   state_next = S_DIV_AVG;
            S_DIV_AVG:
            begin
                if (step_last)
                begin
                    state_next = (close_reg == '0) ? S_DONE : S_DIV_RATIO;
                end
            end
            S_DIV_RATIO:
            begin
                if (step_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            prev_close_reg <= '0;
            smoothed_reg   <= '0;
            bars_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SUM)
            begin
                step_reg <= STEP_BITS'(SUM_BITS - 1);
            end
            else if (state_reg == S_DIV_AVG && step_last)
            begin
                step_reg <= STEP_BITS'(RATIO_STEPS - 1);
            end
            else if (!step_last)
            begin
                step_reg <= step_reg - 1'b1;
            end
            if (state_reg == S_DIV_AVG && step_last)
            begin
                smoothed_reg <= avg_new;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg  <= 1'b1;
                prev_close_reg <= close_reg;
                if (warmup)
                begin
                    bars_reg <= bars_reg + 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            high_reg  <= bar_high;
            low_reg   <= bar_low;
            close_reg <= bar_close;
            quo_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        unique case (state_reg)
            S_DIFF:
            begin
                d_hl_reg <= (high_reg > low_reg) ? (high_reg - low_reg) : '0;
                d_h_reg  <= (high_reg >= prev_close_reg) ? (high_reg - prev_close_reg)
                                                         : (prev_close_reg - high_reg);
                d_l_reg  <= (low_reg >= prev_close_reg) ? (low_reg - prev_close_reg)
                                                        : (prev_close_reg - low_reg);
            end
            S_MAX:
            begin
                tr_reg   <= tr_max;
                prod_reg <= PROD_BITS'(smoothed_reg) * PROD_BITS'(mult_k);
            end
            S_SUM:
            begin
                dvd_reg <= SUM_BITS'(prod_reg) + SUM_BITS'({tr_reg, {FRACTION_BITS{1'b0}}});
                dvs_reg <= PRICE_BITS'(div_n);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            S_DIV_AVG:
            begin
                if (step_last)
                begin
                    dvd_reg <= {avg_new, {(SUM_BITS - AVG_BITS){1'b0}}};
                    dvs_reg <= close_reg;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    sat_reg <= 1'b0;
                end
                else
                begin
                    dvd_reg <= {dvd_reg[SUM_BITS-2:0], 1'b0};
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
            end
            S_DIV_RATIO:
            begin
                dvd_reg <= {dvd_reg[SUM_BITS-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if ((quo_next >> RATIO_BITS) != '0)
                begin
                    sat_reg <= 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    avg_out_reg   <= AVG_OUT_BITS'(smoothed_reg);
                    ratio_out_reg <= sat_reg ? RATIO_MAX : quo_reg[RATIO_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
